[hw/rtl/rc_bind_and_control_packet_builder_core_assert.svh]
// Assertion macros shared by the packet builder modules.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message string.
`ifndef RC_BIND_AND_CONTROL_PACKET_BUILDER_CORE_ASSERT_SVH
`define RC_BIND_AND_CONTROL_PACKET_BUILDER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCBCP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCBCP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rcbcp_pkg.sv]
`timescale 1ns / 1ps

package rcbcp_pkg;

    localparam int CHANNEL_LIMIT = 10000;
    localparam int STICK_TOP     = 225;

    localparam int CH_W      = 16;
    localparam int IN_CHANS  = 9;
    localparam int S_TDATA_W = CH_W * IN_CHANS;
    localparam int ADDR_W    = 40;
    localparam int COUNT_W   = 16;
    localparam int CFG_IDX_W = 8;
    localparam int BYTE_W    = 8;
    localparam int STICKS    = 4;

    localparam logic [COUNT_W-1:0] BIND_PACKETS_RESET = 16'd300;

    localparam logic [CFG_IDX_W-1:0] REG_TX_ADDRESS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIND_PACKETS = 8'd1;

    // Stick scaling: q = floor(STICK_TOP * d / SPAN), done as d * K >> SHIFT
    // with K holding STICK_TOP times a rounded-up reciprocal of SPAN.
    localparam int SPAN  = 2 * CHANNEL_LIMIT;
    localparam int D_W   = $clog2(SPAN + 1);
    localparam int N_W   = $clog2(STICK_TOP * SPAN + 1);
    localparam int SHIFT = N_W + $clog2(SPAN);
    localparam longint unsigned RECIP   = ((64'd1 << SHIFT) + SPAN - 1) / SPAN;
    localparam longint unsigned SCALE_K = longint'(STICK_TOP) * RECIP;
    localparam int K_W   = $clog2(SCALE_K + 1);
    localparam int MUL_W = (D_W + K_W > SHIFT + BYTE_W) ? D_W + K_W : SHIFT + BYTE_W;

    localparam logic [STICKS-1:0] STICK_INVERT = 4'b1010;

    localparam int FRAME_BYTES = 10;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] BIND_LAST = 4'd8;
    localparam logic [IDX_W-1:0] DATA_LAST = 4'd9;

    localparam logic [BYTE_W-1:0] BIND_HDR0     = 8'h18;
    localparam logic [BYTE_W-1:0] BIND_HDR1     = 8'h04;
    localparam logic [BYTE_W-1:0] BIND_HDR2     = 8'h06;
    localparam logic [BYTE_W-1:0] TRIM_BYTE     = 8'h20;
    localparam logic [BYTE_W-1:0] ZERO_BYTE     = 8'h00;
    localparam logic [BYTE_W-1:0] FLAG_BASE     = 8'h02;
    localparam logic [BYTE_W-1:0] FLIP_MASK     = 8'h80;
    localparam logic [BYTE_W-1:0] HEADLESS_MASK = 8'h10;
    localparam logic [BYTE_W-1:0] HOME_MASK     = 8'h08;
    localparam logic [BYTE_W-1:0] LED_MASK      = 8'h04;

    localparam logic [1:0] TOGGLE_RISE = 2'b01;
    localparam logic [1:0] TOGGLE_FALL = 2'b10;

    typedef enum logic {
        PHASE_BIND,
        PHASE_DATA
    } link_phase_t;

    typedef struct packed {
        logic                        is_bind;
        logic [STICKS-1:0][D_W-1:0]  stick_d;
        logic [1:0]                  toggles;
        logic [BYTE_W-1:0]           flags;
    } p1_t;

    typedef struct packed {
        logic                          is_bind;
        logic [STICKS-1:0][BYTE_W-1:0] stick;
        logic [BYTE_W-1:0]             toggle_byte;
        logic [BYTE_W-1:0]             flags;
    } p2_t;

    function automatic logic is_positive(input logic signed [CH_W-1:0] v);
        return !v[CH_W-1] && (v != '0);
    endfunction

    function automatic logic [D_W-1:0] clamp_offset(input logic signed [CH_W-1:0] v);
        logic signed [CH_W:0] ext;
        logic signed [CH_W:0] lim;
        lim = (CH_W+1)'(CHANNEL_LIMIT);
        ext = (CH_W+1)'(v);
        if (ext > lim) begin
            ext = lim;
        end
        if (ext < -lim) begin
            ext = -lim;
        end
        return D_W'(ext + lim);
    endfunction

endpackage

[hw/rtl/rcbcp_ctrl.sv]
`timescale 1ns / 1ps

`include "rc_bind_and_control_packet_builder_core_assert.svh"

module rcbcp_ctrl import rcbcp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic [COUNT_W-1:0]   bind_packets,
    output logic                 p1_valid,
    output p1_t                  p1_data,
    input  logic                 p1_ready
);

    link_phase_t          link_phase_reg, link_phase_next;
    logic [COUNT_W-1:0]   bind_left_reg, bind_left_next;
    logic [1:0]           arm_toggles_reg, arm_toggles_next;
    logic                 arm_seen_high_reg, arm_seen_high_next;
    logic                 p1_valid_reg;
    p1_t                  p1_reg;
    p1_t                  p1_new;
    logic                 s_accept;
    logic                 emit;
    logic                 arm_hi;

    logic signed [CH_W-1:0] throttle, rudder, aileron, elevator;
    logic signed [CH_W-1:0] arm_level, led_level, flip_level, headless_level, home_level;

    assign throttle       = s_tdata[0*CH_W +: CH_W];
    assign rudder         = s_tdata[1*CH_W +: CH_W];
    assign aileron        = s_tdata[2*CH_W +: CH_W];
    assign elevator       = s_tdata[3*CH_W +: CH_W];
    assign arm_level      = s_tdata[4*CH_W +: CH_W];
    assign led_level      = s_tdata[5*CH_W +: CH_W];
    assign flip_level     = s_tdata[6*CH_W +: CH_W];
    assign headless_level = s_tdata[7*CH_W +: CH_W];
    assign home_level     = s_tdata[8*CH_W +: CH_W];

    assign s_tready = !p1_valid_reg || p1_ready;
    assign s_accept = s_tvalid && s_tready;
    assign arm_hi   = is_positive(arm_level);
    assign p1_valid = p1_valid_reg;
    assign p1_data  = p1_reg;

    always_comb begin
        link_phase_next    = link_phase_reg;
        bind_left_next     = bind_left_reg;
        arm_toggles_next   = arm_toggles_reg;
        arm_seen_high_next = arm_seen_high_reg;
        if (s_accept) begin
            if (s_tuser) begin
                link_phase_next    = PHASE_BIND;
                bind_left_next     = bind_packets;
                arm_toggles_next   = '0;
                arm_seen_high_next = arm_hi;
            end else if (link_phase_reg == PHASE_BIND) begin
                if (bind_left_reg == '0) begin
                    link_phase_next = PHASE_DATA;
                end else begin
                    bind_left_next = bind_left_reg - 1'b1;
                end
            end else if (arm_hi != arm_seen_high_reg) begin
                arm_seen_high_next = arm_hi;
                arm_toggles_next   = arm_toggles_reg ^ (arm_hi ? TOGGLE_RISE : TOGGLE_FALL);
            end
        end
    end

    always_comb begin
        emit = s_accept && !s_tuser
            && ((link_phase_reg == PHASE_DATA) || (bind_left_reg != '0));
        p1_new.is_bind    = (link_phase_reg == PHASE_BIND);
        p1_new.stick_d[0] = clamp_offset(throttle);
        p1_new.stick_d[1] = clamp_offset(rudder);
        p1_new.stick_d[2] = clamp_offset(aileron);
        p1_new.stick_d[3] = clamp_offset(elevator);
        p1_new.toggles    = arm_toggles_next;
        p1_new.flags      = FLAG_BASE
            | (is_positive(flip_level)     ? FLIP_MASK     : ZERO_BYTE)
            | (is_positive(headless_level) ? HEADLESS_MASK : ZERO_BYTE)
            | (is_positive(home_level)     ? HOME_MASK     : ZERO_BYTE)
            | (is_positive(led_level)      ? LED_MASK      : ZERO_BYTE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_phase_reg    <= PHASE_BIND;
            bind_left_reg     <= BIND_PACKETS_RESET;
            arm_toggles_reg   <= '0;
            arm_seen_high_reg <= 1'b0;
            p1_valid_reg      <= 1'b0;
        end else begin
            link_phase_reg    <= link_phase_next;
            bind_left_reg     <= bind_left_next;
            arm_toggles_reg   <= arm_toggles_next;
            arm_seen_high_reg <= arm_seen_high_next;
            if (s_accept) begin
                p1_valid_reg <= emit;
            end else if (p1_ready) begin
                p1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            p1_reg <= p1_new;
        end
    end

    `RCBCP_ASSERT_NEXT(a_data_phase_sticky, aclk, aresetn,
        (link_phase_reg == PHASE_DATA) && !(s_accept && s_tuser),
        link_phase_reg == PHASE_DATA, "data phase left without a restart")

    `RCBCP_ASSERT_NEXT(a_bind_frame_issued, aclk, aresetn,
        s_accept && !s_tuser && (link_phase_reg == PHASE_BIND) && (bind_left_reg != '0),
        p1_valid_reg && p1_reg.is_bind, "bind tick with frames left gave no bind frame")

endmodule

[hw/rtl/rcbcp_scale.sv]
`timescale 1ns / 1ps

module rcbcp_scale import rcbcp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic p1_valid,
    input  p1_t  p1_data,
    output logic p1_ready,
    output logic p2_valid,
    output p2_t  p2_data,
    input  logic p2_ready
);

    logic              p2_valid_reg;
    p2_t               p2_reg;
    p2_t               p2_new;
    logic [MUL_W-1:0]  prod [STICKS];
    logic [BYTE_W-1:0] quot [STICKS];

    assign p1_ready = !p2_valid_reg || p2_ready;
    assign p2_valid = p2_valid_reg;
    assign p2_data  = p2_reg;

    always_comb begin
        for (int i = 0; i < STICKS; i++) begin
            prod[i] = MUL_W'(p1_data.stick_d[i]) * MUL_W'(SCALE_K);
            quot[i] = prod[i][SHIFT +: BYTE_W];
            p2_new.stick[i] = STICK_INVERT[i] ? BYTE_W'(STICK_TOP) - quot[i] : quot[i];
        end
        p2_new.is_bind     = p1_data.is_bind;
        p2_new.toggle_byte = {p1_data.toggles, 6'd0};
        p2_new.flags       = p1_data.flags;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (p1_ready) begin
            p2_valid_reg <= p1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_ready && p1_valid) begin
            p2_reg <= p2_new;
        end
    end

endmodule

[hw/rtl/rcbcp_frame.sv]
`timescale 1ns / 1ps

`include "rc_bind_and_control_packet_builder_core_assert.svh"

module rcbcp_frame import rcbcp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              p2_valid,
    input  p2_t               p2_data,
    output logic              p2_ready,
    input  logic [ADDR_W-1:0] tx_address,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);

    logic [FRAME_BYTES-1:0][BYTE_W-1:0] frame_reg, frame_next;
    logic [IDX_W-1:0]                   last_reg, last_next;
    logic [IDX_W-1:0]                   idx_reg;
    logic                               bind_reg;
    logic                               valid_reg;
    logic                               at_last;
    logic                               load;

    assign at_last  = (idx_reg == last_reg);
    assign p2_ready = !valid_reg || (m_tready && at_last);
    assign load     = p2_valid && p2_ready;

    assign m_tvalid = valid_reg;
    assign m_tdata  = frame_reg[idx_reg];
    assign m_tlast  = at_last;
    assign m_tuser  = bind_reg;

    always_comb begin
        logic [BYTE_W-1:0] sum;
        sum        = '0;
        frame_next = '0;
        if (p2_data.is_bind) begin
            frame_next[0] = BIND_HDR0;
            frame_next[1] = BIND_HDR1;
            frame_next[2] = BIND_HDR2;
            for (int i = 0; i < 5; i++) begin
                frame_next[3 + i] = tx_address[BYTE_W*i +: BYTE_W];
                sum = sum + tx_address[BYTE_W*i +: BYTE_W];
            end
            frame_next[8] = sum;
            last_next     = BIND_LAST;
        end else begin
            for (int i = 0; i < STICKS; i++) begin
                frame_next[i] = p2_data.stick[i];
            end
            frame_next[4] = TRIM_BYTE;
            frame_next[5] = TRIM_BYTE;
            frame_next[6] = p2_data.toggle_byte;
            frame_next[7] = p2_data.flags;
            frame_next[8] = ZERO_BYTE;
            for (int i = 0; i < 9; i++) begin
                sum = sum + frame_next[i];
            end
            frame_next[9] = sum;
            last_next     = DATA_LAST;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (valid_reg && m_tready) begin
            if (at_last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            frame_reg <= frame_next;
            last_reg  <= last_next;
            bind_reg  <= p2_data.is_bind;
        end
    end

    `RCBCP_ASSERT_SAME(a_idx_in_frame, aclk, aresetn,
        valid_reg, idx_reg <= last_reg, "byte index ran past the frame end")

    `RCBCP_ASSERT_NEXT(a_stall_holds, aclk, aresetn,
        valid_reg && !m_tready, valid_reg && $stable(idx_reg) && $stable(bind_reg),
        "frame position moved while the output was stalled")

endmodule

[hw/rtl/rc_bind_and_control_packet_builder_core.sv]
`timescale 1ns / 1ps

// Builds the payload bytes of an RC link, one byte per output request.
// Input channel (s_): one request per packet tick. tuser set restarts binding
// and gives no bytes; otherwise a bind phase tick gives a 9-byte bind frame, the
// tick that finds the bind count spent gives nothing and switches to data, and
// every later tick gives a 10-byte control frame.
// Output channel (m_): tdata is the frame byte, tlast marks the final byte and
// tuser is high for bind frame bytes.
// Configuration channel (cfg_): index 0 writes the 40-bit address, index 1 the
// bind frame count; it is always ready. The user must see that it is written
// only while the block is idle; the block itself does not enforce this. Each
// request passes the clamp register, the multiplier register and then the frame
// register before its first byte is shown. Throughput: one byte per cycle while
// m_tready is high, set by the byte-wide frame serializer.
// When the receiver stalls, the current byte is held and up to two more frames
// wait in the pipeline before s_tready drops.
// Reset: address zero, bind count 300, bind phase with 300 frames to send.

module rc_bind_and_control_packet_builder_core import rcbcp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // throttle, rudder, aileron, elevator, arm_level, led_level,
    // flip_level, headless_level, home_level (16 bits each, low to high)
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // frame_byte
    output logic [7:0]           m_tdata,
    output logic                 m_tlast,
    // is_bind
    output logic                 m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    logic [ADDR_W-1:0]  tx_address_reg;
    logic [COUNT_W-1:0] bind_packets_reg;
    logic               p1_valid, p1_ready;
    p1_t                p1_data;
    logic               p2_valid, p2_ready;
    p2_t                p2_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_address_reg   <= '0;
            bind_packets_reg <= BIND_PACKETS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TX_ADDRESS:   tx_address_reg   <= cfg_data;
                REG_BIND_PACKETS: bind_packets_reg <= cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rcbcp_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .bind_packets (bind_packets_reg),
        .p1_valid     (p1_valid),
        .p1_data      (p1_data),
        .p1_ready     (p1_ready)
    );

    rcbcp_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .p1_valid (p1_valid),
        .p1_data  (p1_data),
        .p1_ready (p1_ready),
        .p2_valid (p2_valid),
        .p2_data  (p2_data),
        .p2_ready (p2_ready)
    );

    rcbcp_frame u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .p2_valid   (p2_valid),
        .p2_data    (p2_data),
        .p2_ready   (p2_ready),
        .tx_address (tx_address_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

[sim/tb_rc_bind_and_control_packet_builder_core.sv]
`timescale 1ns / 1ps

module tb_rc_bind_and_control_packet_builder_core;
    import rcbcp_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 12;

    // One packet tick as it travels in s_tdata, throttle in the lowest bits.
    typedef struct packed {
        logic [15:0] home;
        logic [15:0] headless;
        logic [15:0] flip;
        logic [15:0] led;
        logic [15:0] arm;
        logic [15:0] elevator;
        logic [15:0] aileron;
        logic [15:0] rudder;
        logic [15:0] throttle;
    } tick_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_bind;
    } frame_byte_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data  = '0;

    rc_bind_and_control_packet_builder_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Shadow of the block's registers and state.
    logic [ADDR_W-1:0]  reg_addr       = '0;
    logic [COUNT_W-1:0] reg_bind_count = BIND_PACKETS_RESET;
    link_phase_t        mdl_phase      = PHASE_BIND;
    logic [COUNT_W-1:0] mdl_bind_left  = BIND_PACKETS_RESET;
    logic [1:0]         mdl_toggles    = '0;
    logic               mdl_arm_high   = 1'b0;

    frame_byte_t pending_bytes [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int cycle_count   = 0;
    int ticks_sent    = 0;
    int restarts_sent = 0;
    int bytes_checked = 0;
    int bind_frames   = 0;
    int data_frames   = 0;
    int hold_left     = 0;
    bit hold_req      = 1'b0;
    bit hold_ack      = 1'b0;

    function automatic logic switch_on(input logic [15:0] v);
        return $signed(v) > 0;
    endfunction

    function automatic logic [7:0] scale_stick(input logic [15:0] v, input bit inverted);
        int c;
        int q;
        c = $signed(v);
        if (c > CHANNEL_LIMIT) c = CHANNEL_LIMIT;
        if (c < -CHANNEL_LIMIT) c = -CHANNEL_LIMIT;
        q = (STICK_TOP * (c + CHANNEL_LIMIT)) / (2 * CHANNEL_LIMIT);
        return inverted ? 8'(STICK_TOP - q) : 8'(q);
    endfunction

    function automatic void predict_frame(input logic mode, input tick_t t);
        logic [7:0] f [10];
        logic [7:0] sum;
        logic [7:0] flags;
        logic       hi;
        frame_byte_t e;
        sum = '0;
        if (mode) begin
            mdl_phase     = PHASE_BIND;
            mdl_bind_left = reg_bind_count;
            mdl_toggles   = '0;
            mdl_arm_high  = switch_on(t.arm);
            return;
        end
        if (mdl_phase == PHASE_BIND) begin
            if (mdl_bind_left == 0) begin
                mdl_phase = PHASE_DATA;
                return;
            end
            f[0] = BIND_HDR0;
            f[1] = BIND_HDR1;
            f[2] = BIND_HDR2;
            for (int i = 0; i < 5; i++) begin
                f[3 + i] = reg_addr[8 * i +: 8];
                sum += f[3 + i];
            end
            f[8] = sum;
            for (int i = 0; i < 9; i++) begin
                e.data    = f[i];
                e.last    = (i == 8);
                e.is_bind = 1'b1;
                pending_bytes.push_back(e);
            end
            mdl_bind_left = mdl_bind_left - 1'b1;
            return;
        end
        hi = switch_on(t.arm);
        if (hi != mdl_arm_high) begin
            mdl_arm_high = hi;
            mdl_toggles ^= hi ? TOGGLE_RISE : TOGGLE_FALL;
        end
        f[0] = scale_stick(t.throttle, 1'b0);
        f[1] = scale_stick(t.rudder, 1'b1);
        f[2] = scale_stick(t.aileron, 1'b0);
        f[3] = scale_stick(t.elevator, 1'b1);
        f[4] = TRIM_BYTE;
        f[5] = TRIM_BYTE;
        f[6] = {mdl_toggles[1], mdl_toggles[0], 6'b0};
        flags = FLAG_BASE;
        if (switch_on(t.flip)) flags |= FLIP_MASK;
        if (switch_on(t.led)) flags |= LED_MASK;
        if (switch_on(t.headless)) flags |= HEADLESS_MASK;
        if (switch_on(t.home)) flags |= HOME_MASK;
        f[7] = flags;
        f[8] = ZERO_BYTE;
        for (int i = 0; i < 9; i++) sum += f[i];
        f[9] = sum;
        for (int i = 0; i < 10; i++) begin
            e.data    = f[i];
            e.last    = (i == 9);
            e.is_bind = 1'b0;
            pending_bytes.push_back(e);
        end
    endfunction

    function automatic logic [15:0] rand_stick();
        logic [15:0] edges [8];
        int r;
        edges = '{16'h8000, 16'h7FFF, 16'hD8EF, 16'hD8F0, 16'd10000, 16'd10001,
                  16'h0000, 16'hFFFF};
        r = $urandom_range(0, 7);
        if (r == 0) return edges[$urandom_range(0, 7)];
        if (r <= 2) return 16'($urandom);
        return 16'($urandom_range(0, 20000) - 10000);
    endfunction

    function automatic logic [15:0] rand_level(input bit on);
        if (on) return 16'($urandom_range(1, 32767));
        if ($urandom_range(0, 3) == 0) return 16'h0000;
        return 16'(-$urandom_range(1, 32768));
    endfunction

    function automatic tick_t rand_tick(input bit arm_on);
        tick_t t;
        t.throttle = rand_stick();
        t.rudder   = rand_stick();
        t.aileron  = rand_stick();
        t.elevator = rand_stick();
        t.arm      = rand_level(arm_on);
        t.led      = $urandom_range(0, 1) ? 16'($urandom)
                                          : rand_level($urandom_range(0, 1) == 1);
        t.flip     = $urandom_range(0, 1) ? 16'($urandom)
                                          : rand_level($urandom_range(0, 1) == 1);
        t.headless = $urandom_range(0, 1) ? 16'($urandom)
                                          : rand_level($urandom_range(0, 1) == 1);
        t.home     = $urandom_range(0, 1) ? 16'($urandom)
                                          : rand_level($urandom_range(0, 1) == 1);
        return t;
    endfunction

    function automatic tick_t flat_tick(input logic [15:0] stick, input logic [15:0] level);
        tick_t t;
        t.throttle = stick;
        t.rudder   = stick;
        t.aileron  = stick;
        t.elevator = stick;
        t.arm      = level;
        t.led      = level;
        t.flip     = level;
        t.headless = level;
        t.home     = level;
        return t;
    endfunction

    // Leaves s_tvalid high after the handshake so that a following request can
    // start in the same cycle; flush_frames lowers it.
    task automatic send_tick(input logic mode, input tick_t t);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= t;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_frame(mode, t);
        if (mode) restarts_sent++;
        else ticks_sent++;
    endtask

    task automatic flush_frames();
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Writes both registers and then an index past the register list,
    // which must leave them unchanged.
    task automatic set_config(input logic [ADDR_W-1:0] addr, input logic [15:0] count);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [ADDR_W-1:0]    val [3];
        idx[0] = REG_TX_ADDRESS;
        val[0] = addr;
        idx[1] = REG_BIND_PACKETS;
        val[1] = {24'($urandom), count};
        idx[2] = CFG_IDX_W'(REG_BIND_PACKETS + 1 + $urandom_range(0, 253));
        val[2] = ADDR_W'({$urandom, $urandom});
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            if (idx[i] == REG_TX_ADDRESS) reg_addr = val[i];
            else if (idx[i] == REG_BIND_PACKETS) reg_bind_count = val[i][15:0];
        end
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        frame_byte_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected frame byte %02h", m_tdata);
                error_count++;
            end else begin
                e = pending_bytes.pop_front();
                bytes_checked++;
                if (m_tdata !== e.data) begin
                    $error("frame_byte expected %02h actual %02h", e.data, m_tdata);
                    error_count++;
                end
                if (m_tlast !== e.last) begin
                    $error("last expected %0b actual %0b", e.last, m_tlast);
                    error_count++;
                end
                if (m_tuser !== e.is_bind) begin
                    $error("is_bind expected %0b actual %0b", e.is_bind, m_tuser);
                    error_count++;
                end
                if (e.last && e.is_bind) bind_frames++;
                if (e.last && !e.is_bind) data_frames++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_reset_bind();
        send_tick(1'b0, rand_tick(1'b1));
        send_tick(1'b0, flat_tick(16'h8000, 16'h7FFF));
        flush_frames();
    endtask

    task automatic test_data_extremes();
        tick_t t;
        set_config({ADDR_W{1'b1}}, 16'h0000);
        send_tick(1'b1, flat_tick(16'h0000, 16'h8000));
        send_tick(1'b0, flat_tick(16'h0000, 16'h0000));
        send_tick(1'b0, flat_tick(16'h8000, 16'h8000));
        send_tick(1'b0, flat_tick(16'h7FFF, 16'h7FFF));
        send_tick(1'b0, flat_tick(16'hD8F0, 16'h0001));
        send_tick(1'b0, flat_tick(16'd10000, 16'h0000));
        t = flat_tick(16'hD8EF, 16'hFFFF);
        t.rudder   = 16'd10001;
        t.elevator = 16'h0001;
        send_tick(1'b0, t);
        t = flat_tick(16'hFFFF, 16'h0000);
        t.throttle = 16'd9999;
        t.aileron  = 16'h0001;
        t.arm      = 16'h0001;
        t.flip     = 16'h0001;
        t.home     = 16'h7FFF;
        send_tick(1'b0, t);
        t = flat_tick(16'h0000, 16'hFFFF);
        t.led      = 16'h0001;
        t.headless = 16'h4000;
        send_tick(1'b0, t);
        flush_frames();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = ~hold_req;
        for (int i = 0; i < 15; i++) send_tick(1'b0, rand_tick($urandom_range(0, 1) == 1));
        flush_frames();
    endtask

    task automatic test_bind_count();
        set_config(ADDR_W'({$urandom, $urandom}), 16'hFFFF);
        send_tick(1'b1, flat_tick(16'h0000, 16'h0001));
        send_tick(1'b0, rand_tick(1'b1));
        send_tick(1'b0, rand_tick(1'b0));
        flush_frames();
        set_config(ADDR_W'({$urandom, $urandom}), 16'h0001);
        send_tick(1'b0, rand_tick(1'b1));
        send_tick(1'b1, flat_tick(16'h0000, 16'h7FFF));
        send_tick(1'b0, rand_tick(1'b1));
        send_tick(1'b0, rand_tick(1'b1));
        send_tick(1'b0, rand_tick(1'b1));
        send_tick(1'b0, rand_tick(1'b0));
        flush_frames();
    endtask

    task automatic test_random_traffic();
        int send_pct [3];
        int recv_pct [3];
        int sent;
        int run_len;
        bit arm_on;
        send_pct = '{37, 51, 0};
        recv_pct = '{51, 37, 0};
        for (int s = 0; s < 3; s++) begin
            send_idle_pct = send_pct[s];
            recv_idle_pct = recv_pct[s];
            sent = 0;
            while (sent < 140) begin
                set_config(ADDR_W'({$urandom, $urandom}), 16'($urandom_range(0, 4)));
                arm_on = ($urandom_range(0, 1) == 1);
                send_tick(1'b1, rand_tick(arm_on));
                run_len = $urandom_range(25, 50);
                for (int i = 0; i < run_len; i++) begin
                    if ($urandom_range(0, 99) < 30) arm_on = ~arm_on;
                    send_tick($urandom_range(0, 99) < 4, rand_tick(arm_on));
                end
                sent += run_len + 1;
                flush_frames();
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_bind();
        test_data_extremes();
        test_backpressure();
        test_bind_count();
        test_random_traffic();
        flush_frames();
        $display("Sent %0d ticks and %0d restarts; checked %0d bytes in %0d bind and %0d data frames.",
                 ticks_sent, restarts_sent, bytes_checked, bind_frames, data_frames);
        $display("Covered stick and switch extremes, arm toggles, bind counts and a long stall.");
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/rcbcp_pkg.sv
hw/rtl/rcbcp_ctrl.sv
hw/rtl/rcbcp_scale.sv
hw/rtl/rcbcp_frame.sv
hw/rtl/rc_bind_and_control_packet_builder_core.sv
sim/tb_rc_bind_and_control_packet_builder_core.sv
